// ----- rtl/core/hmf_pkg.sv -----
// Shared types and constants of the histogram median filter core.
// Holds the transaction payloads, register indexes and controller/datapath links.
// No dependencies.
package hmf_pkg;

	typedef struct packed {
		logic [15:0] pixel_in;
		logic        pad;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pixel_out;
		logic        frame_last;
	} out_item_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

	localparam logic [2:0]  RADIUS_RST = 3'd1;
	localparam logic [10:0] WIDTH_RST  = 11'd320;
	localparam logic [10:0] HEIGHT_RST = 11'd240;

	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_W      = 10;
	localparam int HGT_W      = 11;
	localparam int BIN_W      = 8;
	localparam int CNT_W      = 8;

	localparam logic [BIN_W-1:0] GREEN_BASE = 8'd32;
	localparam logic [BIN_W-1:0] BLUE_BASE  = 8'd96;
	localparam logic [BIN_W-1:0] RED_END    = 8'd31;
	localparam logic [BIN_W-1:0] GREEN_END  = 8'd95;
	localparam logic [BIN_W-1:0] BLUE_END   = 8'd127;
	localparam logic [BIN_W-1:0] GRAY_END   = 8'd255;

	typedef struct packed {
		logic take;
		logic calc_need;
		logic calc_off;
		logic set_base;
		logic clr;
		logic pix_lat;
		logic bin_rd;
		logic bin_wr;
		logic scan_rd;
		logic scan_acc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic due;
		logic clr_last;
		logic chan_last;
		logic win_last;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/hmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/core/hmf_ctrl.sv -----
// Sequencer of the median filter: steps one transaction through need check,
// histogram clear, window accumulation, rank scan and result hand-off. Uses hmf_pkg.
module hmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hmf_pkg::sts_t sts,
	output hmf_pkg::cmd_t cmd
);
	import hmf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_NEED, S_OFF, S_BASE, S_CLR, S_PRD, S_PWT,
		S_HRD, S_HWR, S_SRD, S_SWT, S_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_NEED;
				S_NEED: state_q <= S_OFF;
				S_OFF:  state_q <= sts.due ? S_BASE : S_IDLE;
				S_BASE: state_q <= S_CLR;
				S_CLR:  if (sts.clr_last) state_q <= S_PRD;
				S_PRD:  state_q <= S_PWT;
				S_PWT:  state_q <= S_HRD;
				S_HRD:  state_q <= S_HWR;
				S_HWR: begin
					if (!sts.chan_last) state_q <= S_HRD;
					else if (sts.win_last) state_q <= S_SRD;
					else state_q <= S_PRD;
				end
				S_SRD:  state_q <= S_SWT;
				S_SWT:  state_q <= sts.scan_last ? S_EMIT : S_SRD;
				S_EMIT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.take      = in_valid;
			S_NEED: cmd.calc_need = 1'b1;
			S_OFF:  cmd.calc_off  = sts.due;
			S_BASE: cmd.set_base  = 1'b1;
			S_CLR:  cmd.clr       = 1'b1;
			S_PRD:  cmd           = '0;
			S_PWT:  cmd.pix_lat   = 1'b1;
			S_HRD:  cmd.bin_rd    = 1'b1;
			S_HWR:  cmd.bin_wr    = 1'b1;
			S_SRD:  cmd.scan_rd   = 1'b1;
			S_SWT:  cmd.scan_acc  = 1'b1;
			S_EMIT: cmd.emit      = sts.out_free;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
endmodule

// ----- rtl/core/hmf_datapath.sv -----
// Datapath of the median filter: registers, frame counters, line store,
// window histogram, rank scan and output register. Uses hmf_pkg and hmf_ram.
module hmf_datapath #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hmf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  hmf_pkg::in_item_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output hmf_pkg::out_item_t                 out_data,
	input  hmf_pkg::cmd_t                      cmd,
	output hmf_pkg::sts_t                      sts
);
	import hmf_pkg::*;

	localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WX    = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
	localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

	// configuration
	logic              color_q;
	logic [2:0]        radius_q;
	logic [10:0]       width_q;
	logic [10:0]       height_q;
	logic [2:0]        r_c;
	logic [CW-1:0]     w_c;
	logic [HGT_W-1:0]  h_c;
	logic [WX-1:0]     wq_x;

	// frame position
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [XW-1:0]     in_col_q, out_col_q;
	logic [PW-1:0]     in_pos_q, need_q;
	logic [AW-1:0]     in_addr_q, out_addr_q;
	logic              done_q;

	// window walk
	logic [ROW_W-1:0]  nr_q, cur_row_q, r0_q;
	logic [XW-1:0]     nc_q, cur_col_q, c0_q;
	logic [2:0]        dr_q, dc_q;
	logic [AW-1:0]     toff_q, row_addr_q, cur_addr_q;
	logic [BIN_W-1:0]  clr_idx_q, scan_idx_q;
	logic [1:0]        chan_q, seg_q;
	logic [CNT_W-1:0]  wc_q;
	logic [CNT_W:0]    acc_q;
	logic              found_q;
	logic [15:0]       pix_q;
	logic [7:0]        med0_q;
	logic [5:0]        med1_q;
	logic [4:0]        med2_q;

	logic              out_valid_q;
	out_item_t         out_data_q;

	// clamps
	always_comb begin
		r_c = radius_q;
		if (radius_q == 3'd0) r_c = 3'd1;
		else if (int'(radius_q) > MAX_RADIUS) r_c = 3'(MAX_RADIUS);
		wq_x = WX'(width_q);
		if (wq_x == '0) w_c = CW'(1);
		else if (wq_x > WX'(MAX_WIDTH)) w_c = CW'(MAX_WIDTH);
		else w_c = CW'(wq_x);
		if (height_q == 11'd0) h_c = 11'd1;
		else if (height_q > 11'(MAX_HEIGHT)) h_c = 11'(MAX_HEIGHT);
		else h_c = height_q;
	end

	// window bounds for the current result position
	logic [HGT_W-1:0]  nr_sum;
	logic [XW:0]       nc_sum;
	logic [ROW_W-1:0]  nr;
	logic [XW-1:0]     nc;
	logic [2:0]        dr, dc;
	logic [ROW_W+CW-1:0] need_prod;

	always_comb begin
		nr_sum = HGT_W'(out_row_q) + HGT_W'(r_c);
		nr     = (nr_sum < h_c) ? nr_sum[ROW_W-1:0] : ROW_W'(h_c - 11'd1);
		nc_sum = (XW+1)'(out_col_q) + (XW+1)'(r_c);
		nc     = (nc_sum < (XW+1)'(w_c)) ? nc_sum[XW-1:0] : XW'(w_c - CW'(1));
		dr     = (out_row_q < ROW_W'(r_c)) ? out_row_q[2:0] : r_c;
		dc     = (out_col_q < XW'(r_c)) ? out_col_q[2:0] : r_c;
		need_prod = (ROW_W+CW)'(nr) * (ROW_W+CW)'(w_c);
	end

	// address helpers
	logic [AW:0]   base_diff;
	logic [AW:0]   row_sum;
	logic [AW-1:0] row_next;
	logic [AW-1:0] cur_inc, in_inc, out_inc;

	always_comb begin
		base_diff = (AW+1)'(out_addr_q) - (AW+1)'(toff_q);
		if (base_diff[AW]) base_diff = base_diff + (AW+1)'(DEPTH);
		row_sum  = (AW+1)'(row_addr_q) + (AW+1)'(w_c);
		row_next = (row_sum >= (AW+1)'(DEPTH)) ? AW'(row_sum - (AW+1)'(DEPTH)) : AW'(row_sum);
		cur_inc  = (cur_addr_q == AW'(DEPTH - 1)) ? '0 : cur_addr_q + AW'(1);
		in_inc   = (in_addr_q == AW'(DEPTH - 1)) ? '0 : in_addr_q + AW'(1);
		out_inc  = (out_addr_q == AW'(DEPTH - 1)) ? '0 : out_addr_q + AW'(1);
	end

	// input side after a possible restart
	logic [ROW_W-1:0] e_row;
	logic [XW-1:0]    e_col;
	logic [PW-1:0]    e_pos;
	logic [AW-1:0]    e_addr, e_addr_inc;
	logic             col_wrap, row_wrap;

	always_comb begin
		e_row  = done_q ? '0 : in_row_q;
		e_col  = done_q ? '0 : in_col_q;
		e_pos  = done_q ? '0 : in_pos_q;
		e_addr = done_q ? '0 : in_addr_q;
		e_addr_inc = done_q ? AW'(1) : in_inc;
		col_wrap = ((XW+1)'(e_col) + (XW+1)'(1)) >= (XW+1)'(w_c);
		row_wrap = (HGT_W'(e_row) + HGT_W'(1)) >= h_c;
	end

	// histogram bin of the latched pixel
	logic [BIN_W-1:0] bin_sel;
	always_comb begin
		if (!color_q) bin_sel = pix_q[7:0];
		else begin
			case (chan_q)
				2'd0:    bin_sel = {3'b000, pix_q[15:11]};
				2'd1:    bin_sel = GREEN_BASE + {2'b00, pix_q[10:5]};
				default: bin_sel = BLUE_BASE + {3'b000, pix_q[4:0]};
			endcase
		end
	end

	// rank scan segment
	logic [BIN_W-1:0] seg_base, seg_end, scan_ofs;
	logic [CNT_W-1:0] hist_rdata;
	logic [CNT_W:0]   acc_new;
	always_comb begin
		if (!color_q) begin
			seg_base = '0;
			seg_end  = GRAY_END;
		end else begin
			case (seg_q)
				2'd0:    begin seg_base = '0;         seg_end = RED_END;   end
				2'd1:    begin seg_base = GREEN_BASE; seg_end = GREEN_END; end
				default: begin seg_base = BLUE_BASE;  seg_end = BLUE_END;  end
			endcase
		end
		scan_ofs = scan_idx_q - seg_base;
		acc_new  = acc_q + (CNT_W+1)'(hist_rdata);
	end

	logic win_last, chan_last, out_last;
	assign chan_last = !color_q || (chan_q == 2'd2);
	assign win_last  = (cur_row_q == nr_q) && (cur_col_q == nc_q);
	assign out_last  = (HGT_W'(out_row_q) == h_c - 11'd1)
		&& ((XW+1)'(out_col_q) == (XW+1)'(w_c - CW'(1)));

	always_comb begin
		sts.due       = in_pos_q > need_q;
		sts.clr_last  = (clr_idx_q == GRAY_END);
		sts.chan_last = chan_last;
		sts.win_last  = win_last;
		sts.scan_last = (scan_idx_q == seg_end) && (!color_q || seg_q == 2'd2);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// memories
	logic [15:0] line_rdata;
	logic        hist_we;
	logic [BIN_W-1:0] hist_waddr, hist_raddr;
	logic [CNT_W-1:0] hist_wdata;

	assign hist_we    = cmd.clr || cmd.bin_wr;
	assign hist_waddr = cmd.clr ? clr_idx_q : bin_sel;
	assign hist_wdata = cmd.clr ? '0 : hist_rdata + CNT_W'(1);
	assign hist_raddr = cmd.scan_rd ? scan_idx_q : bin_sel;

	hmf_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_line (
		.clk   (clk),
		.we    (cmd.take && !in_data.pad),
		.waddr (e_addr),
		.wdata (in_data.pixel_in),
		.raddr (cur_addr_q),
		.rdata (line_rdata)
	);

	hmf_ram #(.WIDTH(CNT_W), .DEPTH(256)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q    <= 1'b0;
			radius_q   <= RADIUS_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_pos_q   <= '0;
			in_addr_q  <= '0;
			done_q     <= 1'b0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.emit) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLOR_MODE:   color_q  <= cfg_wdata[0];
					REG_RADIUS:       radius_q <= cfg_wdata[2:0];
					REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
					REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
					default: ;
				endcase
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_pos_q   <= '0;
				in_addr_q  <= '0;
				done_q     <= 1'b0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_addr_q <= '0;
			end else if (cmd.take && !in_data.pad) begin
				in_pos_q  <= e_pos + PW'(1);
				in_addr_q <= e_addr_inc;
				if (done_q) begin
					out_row_q  <= '0;
					out_col_q  <= '0;
					out_addr_q <= '0;
				end
				if (col_wrap) begin
					in_col_q <= '0;
					if (row_wrap) begin
						in_row_q <= '0;
						done_q   <= 1'b1;
					end else begin
						in_row_q <= e_row + ROW_W'(1);
						done_q   <= 1'b0;
					end
				end else begin
					in_col_q <= e_col + XW'(1);
					in_row_q <= e_row;
					done_q   <= 1'b0;
				end
			end else if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (out_last) begin
					in_row_q   <= '0;
					in_col_q   <= '0;
					in_pos_q   <= '0;
					in_addr_q  <= '0;
					done_q     <= 1'b0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					out_addr_q <= '0;
				end else begin
					out_addr_q <= out_inc;
					if ((XW+1)'(out_col_q) + (XW+1)'(1) >= (XW+1)'(w_c)) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + XW'(1);
					end
				end
			end
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.calc_need) begin
			need_q <= PW'(need_prod) + PW'(nc);
			nr_q   <= nr;
			nc_q   <= nc;
			dr_q   <= dr;
			dc_q   <= dc;
			r0_q   <= out_row_q - ROW_W'(dr);
			c0_q   <= out_col_q - XW'(dc);
		end
		if (cmd.calc_off) begin
			toff_q <= AW'(AW'(dr_q) * AW'(w_c)) + AW'(dc_q);
		end
		if (cmd.set_base) begin
			row_addr_q <= AW'(base_diff);
			cur_addr_q <= AW'(base_diff);
			cur_row_q  <= r0_q;
			cur_col_q  <= c0_q;
			wc_q       <= '0;
			clr_idx_q  <= '0;
			scan_idx_q <= '0;
			seg_q      <= '0;
			acc_q      <= '0;
			found_q    <= 1'b0;
			med0_q     <= color_q ? {3'b000, RED_END[4:0]} : GRAY_END;
			med1_q     <= 6'h3F;
			med2_q     <= 5'h1F;
		end
		if (cmd.clr) clr_idx_q <= clr_idx_q + BIN_W'(1);
		if (cmd.pix_lat) begin
			pix_q  <= line_rdata;
			chan_q <= '0;
			wc_q   <= wc_q + CNT_W'(1);
		end
		if (cmd.bin_wr) begin
			if (!chan_last) chan_q <= chan_q + 2'd1;
			else if (cur_col_q == nc_q) begin
				cur_col_q  <= c0_q;
				cur_row_q  <= cur_row_q + ROW_W'(1);
				row_addr_q <= row_next;
				cur_addr_q <= row_next;
			end else begin
				cur_col_q  <= cur_col_q + XW'(1);
				cur_addr_q <= cur_inc;
			end
		end
		if (cmd.scan_acc) begin
			if (!found_q && acc_new > (CNT_W+1)'(wc_q >> 1)) begin
				case (seg_q)
					2'd0:    med0_q <= scan_ofs;
					2'd1:    med1_q <= scan_ofs[5:0];
					default: med2_q <= scan_ofs[4:0];
				endcase
			end
			if (scan_idx_q == seg_end) begin
				acc_q   <= '0;
				found_q <= 1'b0;
				seg_q   <= seg_q + 2'd1;
			end else begin
				acc_q <= acc_new;
				if (!found_q && acc_new > (CNT_W+1)'(wc_q >> 1)) found_q <= 1'b1;
			end
			scan_idx_q <= scan_idx_q + BIN_W'(1);
		end
		if (cmd.emit) begin
			out_data_q.pixel_out  <= color_q ? {med0_q[4:0], med1_q, med2_q} : {8'h00, med0_q};
			out_data_q.frame_last <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule

// ----- rtl/core/histogram_median_filter_core.sv -----
// Histogram median filter core: top level joining sequencer and datapath.
// Uses hmf_pkg, hmf_ctrl, hmf_datapath (and hmf_ram through the datapath).
//
// Usage: raster pixels (gray in bits 7:0 or RGB565) enter on in_valid/in_stall/
// in_data; each transaction gives zero or one filtered pixel on out_valid/
// out_stall/out_data, in raster order, with frame_last on the final pixel.
// A pad transaction carries no pixel and only lets a queued result out.
// Registers are written through cfg_we/cfg_index/cfg_wdata while idle; any
// write restarts the frame. One transaction is in work at a time; in_stall
// is high from acceptance until it is finished.
// Steps: with no result due the transaction ends after the need check;
// otherwise the histogram is cleared (all 256 bins), each window pixel adds
// 1 gray or 3 RGB bins, one read-modify-write of the histogram RAM each, and
// the rank scan walks 256 gray or 128 RGB bins before the result hand-off.
// The result register frees the core for the next transaction while a result
// waits; a stalled result holds the core only at its next hand-off.
// Reset clears configuration, frame counters and the valid flag to defaults;
// work registers, output data, histogram and line store keep no reset value.
module histogram_median_filter_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  hmf_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output hmf_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic [hmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import hmf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	hmf_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core accepted back-to-back transactions");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	a_emit_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");
endmodule
